>>> rtl/core/rational_arith_reduce_top_macros.svh
// Assertion helpers used by the top-level RTL file of this block.
`ifndef RATIONAL_ARITH_REDUCE_TOP_MACROS_SVH
`define RATIONAL_ARITH_REDUCE_TOP_MACROS_SVH

// Check that an antecedent implies a consequent in the same cycle.
`define RAR_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check that an antecedent implies a consequent in the following cycle.
`define RAR_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/core/rar_pkg.sv
package rar_pkg;

    // Operation codes
    localparam logic [1:0] OP_ADD = 2'd0;
    localparam logic [1:0] OP_SUB = 2'd1;
    localparam logic [1:0] OP_MUL = 2'd2;
    localparam logic [1:0] OP_DIV = 2'd3;

    localparam int NUM_W = 63;
    localparam int DEN_W = 61;
    localparam int MAG_W = 62;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [30:0] num_a;
        logic [30:0] den_a;
        logic [30:0] num_b;
        logic [30:0] den_b;
    } t_req;

    typedef struct packed {
        logic [62:0] res_num;
        logic [60:0] res_den;
        logic        status;
    } t_res;

    // Divider handshake signals
    typedef struct packed {
        logic start;
    } t_div_ctl;

    typedef struct packed {
        logic busy;
        logic done;
    } t_div_sts;

endpackage

>>> rtl/core/rational_arith_reduce_top.sv
// Exact add, subtract, multiply or divide of two signed fractions, result in
// lowest terms with a positive denominator. One request at a time: raise
// start while busy is low; o_done pulses for one cycle with the result and
// cannot be held off, so capture it then. A request forms the products and
// the signed sum, then runs the remainder steps of the Euclidean gcd, the
// final gcd check, the two final divisions and the delivery of the result;
// the gcd steps and divisions share one 62-bit restoring divider that yields
// one bit per cycle, and the number of gcd steps depends on the operands.
// Errors finish in the cycle after the beat is taken; zero results skip the
// gcd steps and divisions and go from the gcd check straight to output.
`include "rational_arith_reduce_top_macros.svh"

module rational_arith_reduce_top #(
    parameter int OPERAND_BITS = 31
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          start,
    output logic          busy,
    input  rar_pkg::t_req i_req,
    output logic          o_done,
    output rar_pkg::t_res o_res
);
    localparam int W  = rar_pkg::MAG_W;
    localparam int OB = OPERAND_BITS;

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_MUL1 = 4'd1;
    localparam logic [3:0] S_MUL2 = 4'd2;
    localparam logic [3:0] S_SUM  = 4'd3;
    localparam logic [3:0] S_GCHK = 4'd4;
    localparam logic [3:0] S_GDIV = 4'd5;
    localparam logic [3:0] S_NDIV = 4'd6;
    localparam logic [3:0] S_DDIV = 4'd7;
    localparam logic [3:0] S_OUT  = 4'd8;

    logic [3:0]   r_st, n_st;
    logic [1:0]   r_op;
    logic [OB-1:0] r_mna, r_mda, r_mnb, r_mdb;
    logic         r_sna, r_sda, r_snb, r_sdb;
    logic [W-1:0] r_p1, r_p2;
    logic         r_s1, r_s2;
    logic [W-1:0] r_nmag, r_dmag, r_x, r_y;
    logic         r_nneg, r_dneg;
    logic         r_done;
    rar_pkg::t_res r_res;

    logic [OB-1:0] w_na, w_da, w_nb, w_db;
    logic [2*OB-1:0] w_pa, w_pb, w_pd;
    logic [OB-1:0] w_m1a, w_m1b, w_m2a, w_m2b;
    logic [W:0]    w_sum;
    logic          w_acc;
    logic          w_err;
    logic          w_div_free;

    rar_pkg::t_div_ctl w_dctl;
    rar_pkg::t_div_sts w_dsts;
    logic [W-1:0]      w_dvd, w_dvs, w_quot, w_rem;

    function automatic logic [OB-1:0] f_mag(input logic [OB-1:0] v);
        f_mag = v[OB-1] ? (~v + 1'b1) : v;
    endfunction

    assign w_na  = f_mag(i_req.num_a[OB-1:0]);
    assign w_da  = f_mag(i_req.den_a[OB-1:0]);
    assign w_nb  = f_mag(i_req.num_b[OB-1:0]);
    assign w_db  = f_mag(i_req.den_b[OB-1:0]);
    assign w_acc = start && !busy;
    assign w_err = (w_da == '0) || (w_db == '0) ||
                   (i_req.req_type == rar_pkg::OP_DIV && w_nb == '0);

    // Form the two products, operands picked by operation (cross products for add, subtract and divide)
    always_comb begin
        w_m1a = r_mna;
        w_m1b = r_mdb;
        w_m2a = r_mda;
        w_m2b = r_mdb;
        case (r_op)
            rar_pkg::OP_ADD, rar_pkg::OP_SUB: begin
                w_m2a = r_mnb; w_m2b = r_mda;
            end
            rar_pkg::OP_MUL: begin
                w_m1b = r_mnb;
            end
            default: begin
                w_m2a = r_mnb; w_m2b = r_mda;
            end
        endcase
    end
    assign w_pa = w_m1a * w_m1b;
    assign w_pb = w_m2a * w_m2b;
    assign w_pd = r_mda * r_mdb;

    // Signed combine for add and subtract on magnitudes with signs
    logic [W:0] w_t1, w_t2;
    assign w_t1  = r_s1 ? -{1'b0, r_p1} : {1'b0, r_p1};
    assign w_t2  = r_s2 ? -{1'b0, r_p2} : {1'b0, r_p2};
    assign w_sum = (r_op == rar_pkg::OP_ADD) ? (w_t1 + w_t2) : (w_t1 - w_t2);

    // Start a final division only once, while the divider sits idle
    assign w_div_free = !w_dsts.busy && !w_dsts.done;

    // Divider operands follow the sequencer step
    always_comb begin
        w_dctl.start = 1'b0;
        w_dvd = r_x;
        w_dvs = r_y;
        case (r_st)
            S_GCHK:  w_dctl.start = (r_nmag != '0) && (r_y != '0);
            S_NDIV:  begin w_dvd = r_nmag; w_dvs = r_x; w_dctl.start = w_div_free; end
            S_DDIV:  begin w_dvd = r_dmag; w_dvs = r_x; w_dctl.start = w_div_free; end
            default: w_dctl.start = 1'b0;
        endcase
    end

    rar_divu u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (w_dctl),
        .i_dividend (w_dvd),
        .i_divisor  (w_dvs),
        .o_sts      (w_dsts),
        .o_quot     (w_quot),
        .o_rem      (w_rem)
    );

    // Next-state sequencing
    always_comb begin
        n_st = r_st;
        case (r_st)
            S_IDLE: if (w_acc && !w_err) n_st = S_MUL1;
            S_MUL1: n_st = S_MUL2;
            S_MUL2: n_st = S_SUM;
            S_SUM:  n_st = S_GCHK;
            S_GCHK: begin
                if (r_nmag == '0)  n_st = S_OUT;
                else if (r_y == '0) n_st = S_NDIV;
                else               n_st = S_GDIV;
            end
            S_GDIV: if (w_dsts.done) n_st = S_GCHK;
            S_NDIV: if (w_dsts.done) n_st = S_DDIV;
            S_DDIV: if (w_dsts.done) n_st = S_OUT;
            S_OUT:  n_st = S_IDLE;
            default: n_st = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st   <= S_IDLE;
            r_done <= 1'b0;
        end else begin
            r_st   <= n_st;
            r_done <= (r_st == S_OUT) || (w_acc && w_err);
        end
        // Capture operands on an accepted beat
        if (w_acc) begin
            r_op  <= i_req.req_type;
            r_mna <= w_na;
            r_mda <= w_da;
            r_mnb <= w_nb;
            r_mdb <= w_db;
            r_sna <= i_req.num_a[OB-1];
            r_sda <= i_req.den_a[OB-1];
            r_snb <= i_req.num_b[OB-1];
            r_sdb <= i_req.den_b[OB-1];
            if (w_err) begin
                r_res.res_num <= '0;
                r_res.res_den <= '0;
                r_res.status  <= 1'b1;
            end
        end
        case (r_st)
            S_MUL1: begin
                r_p1 <= W'(w_pa);
                r_p2 <= W'(w_pb);
                r_s1 <= r_sna ^ ((r_op == rar_pkg::OP_MUL) ? r_snb : r_sdb);
                r_s2 <= r_snb ^ r_sda;
            end
            S_MUL2: begin
                // Denominator product for add, subtract and multiply; the second cross product for divide
                r_dmag <= (r_op == rar_pkg::OP_DIV) ? r_p2 : W'(w_pd);
                r_dneg <= (r_op == rar_pkg::OP_DIV) ? r_s2 : (r_sda ^ r_sdb);
            end
            S_SUM: begin
                if (r_op == rar_pkg::OP_ADD || r_op == rar_pkg::OP_SUB) begin
                    r_nneg <= w_sum[W];
                    r_nmag <= w_sum[W] ? W'(-w_sum) : w_sum[W-1:0];
                    r_x    <= w_sum[W] ? W'(-w_sum) : w_sum[W-1:0];
                end else begin
                    r_nneg <= r_s1;
                    r_nmag <= r_p1;
                    r_x    <= r_p1;
                end
                r_y <= r_dmag;
            end
            S_GDIV: if (w_dsts.done) begin
                r_x <= r_y;
                r_y <= w_rem;
            end
            S_NDIV: if (w_dsts.done) r_nmag <= w_quot;
            S_DDIV: if (w_dsts.done) r_dmag <= w_quot;
            S_OUT: begin
                r_res.status <= 1'b0;
                if (r_nmag == '0) begin
                    r_res.res_num <= '0;
                    r_res.res_den <= rar_pkg::DEN_W'(1);
                end else begin
                    r_res.res_num <= (r_nneg ^ r_dneg) ? -{1'b0, r_nmag} : {1'b0, r_nmag};
                    r_res.res_den <= r_dmag[rar_pkg::DEN_W-1:0];
                end
            end
            default: ;
        endcase
    end

    assign busy   = (r_st != S_IDLE) || r_done;
    assign o_done = r_done;
    assign o_res  = r_res;

    `RAR_ASSERT_NXT(a_err_done, i_clk, i_rst_n, w_acc && w_err, o_done && o_res.status, "error beat must finish next cycle")
    `RAR_ASSERT_IMP(a_den_pos, i_clk, i_rst_n, o_done && !o_res.status, o_res.res_den != '0, "ok result needs nonzero denominator")
    `RAR_ASSERT_IMP(a_div_idle, i_clk, i_rst_n, r_st == S_IDLE, !w_dsts.busy, "divider busy while idle")
endmodule

>>> rtl/core/rar_divu.sv
// Restoring divider: one quotient bit per cycle.
module rar_divu (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  rar_pkg::t_div_ctl        i_ctl,
    input  logic [rar_pkg::MAG_W-1:0] i_dividend,
    input  logic [rar_pkg::MAG_W-1:0] i_divisor,
    output rar_pkg::t_div_sts        o_sts,
    output logic [rar_pkg::MAG_W-1:0] o_quot,
    output logic [rar_pkg::MAG_W-1:0] o_rem
);
    localparam int W  = rar_pkg::MAG_W;
    localparam int CW = $clog2(W + 1);

    logic [W-1:0]  r_q, n_q;
    logic [W-1:0]  r_r, n_r;
    logic [W-1:0]  r_d, n_d;
    logic [CW-1:0] r_cnt, n_cnt;
    logic          r_busy, n_busy;
    logic          r_done, n_done;
    logic [W:0]    w_trial;
    logic [W:0]    w_diff;

    assign w_trial = {r_r, r_q[W-1]};
    assign w_diff  = w_trial - {1'b0, r_d};

    // Load operands on start, then shift in one dividend bit, subtract when it fits
    always_comb begin
        n_q    = r_q;
        n_r    = r_r;
        n_d    = r_d;
        n_cnt  = r_cnt;
        n_busy = r_busy;
        n_done = 1'b0;
        if (i_ctl.start && !r_busy) begin
            n_q    = i_dividend;
            n_r    = '0;
            n_d    = i_divisor;
            n_cnt  = CW'(W);
            n_busy = 1'b1;
        end else if (r_busy) begin
            if (!w_diff[W]) begin
                n_r = w_diff[W-1:0];
                n_q = {r_q[W-2:0], 1'b1};
            end else begin
                n_r = w_trial[W-1:0];
                n_q = {r_q[W-2:0], 1'b0};
            end
            n_cnt = r_cnt - 1'b1;
            if (r_cnt == CW'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_q <= n_q;
        r_r <= n_r;
        r_d <= n_d;
    end

    assign o_sts.busy = r_busy;
    assign o_sts.done = r_done;
    assign o_quot     = r_q;
    assign o_rem      = r_r;
endmodule
